// ===== hdl/encoder_angle_velocity_tracker_unit_assert.svh =====
// Assertion macros shared by the checker of the encoder angle and velocity tracker.
`ifndef ENCODER_ANGLE_VELOCITY_TRACKER_UNIT_ASSERT_SVH
`define ENCODER_ANGLE_VELOCITY_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define EAVT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define EAVT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== hdl/eavt_pkg.sv =====
// Shared widths, constants and register indexes of the encoder angle and velocity tracker.
`default_nettype none

package eavt_pkg;

	localparam int COUNT_BITS = 14;
	localparam int FRAC_BITS  = 16;

	localparam int ZERO_W  = 14;
	localparam int PP_W    = 7;
	localparam int ALPHA_W = 17;
	localparam int CFG_W   = 17;
	localparam int CFG_A_W = 2;
	localparam int POS_W   = 32;
	localparam int VEL_W   = 31;

	localparam int D_W     = COUNT_BITS + 1;
	localparam int CDIFF_W = COUNT_BITS + 2;
	localparam int RAW_W   = D_W + FRAC_BITS;
	localparam int DIFF_W  = ((RAW_W > VEL_W) ? RAW_W : VEL_W) + 1;
	localparam int PROD_W  = DIFF_W + ALPHA_W + 1;
	localparam int ELEC_W  = COUNT_BITS + PP_W;

	localparam logic [CFG_A_W-1:0] REG_ZERO_OFFSET  = 2'd0;
	localparam logic [CFG_A_W-1:0] REG_POLE_PAIRS   = 2'd1;
	localparam logic [CFG_A_W-1:0] REG_FILTER_ALPHA = 2'd2;

	localparam logic [ZERO_W-1:0]  ZERO_OFFSET_RST  = 14'd9255;
	localparam logic [PP_W-1:0]    POLE_PAIRS_RST   = 7'd7;
	localparam logic [ALPHA_W-1:0] FILTER_ALPHA_RST = 17'd1966;

	localparam logic [ALPHA_W-1:0] Q_ONE = ALPHA_W'(1 << FRAC_BITS);

	localparam logic signed [CDIFF_W-1:0] CNT_HALF = CDIFF_W'(1 << (COUNT_BITS - 1));
	localparam logic signed [CDIFF_W-1:0] CNT_FULL = CDIFF_W'(1 << COUNT_BITS);

	localparam logic signed [PROD_W-1:0] VEL_MAX_X =
		{{(PROD_W - VEL_W + 1){1'b0}}, {(VEL_W - 1){1'b1}}};
	localparam logic signed [PROD_W-1:0] VEL_MIN_X =
		{{(PROD_W - VEL_W + 1){1'b1}}, {(VEL_W - 1){1'b0}}};
	localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W - 1){1'b1}}};
	localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W - 1){1'b0}}};
	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W - 1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W - 1){1'b0}}};

endpackage

`default_nettype wire

// ===== hdl/encoder_angle_velocity_tracker_unit.sv =====
// Top level of the encoder angle and velocity tracker: unwrap, electrical angle and IIR velocity.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------------
//  input   | in_valid / in_stall | raw_count
//  output  | out_valid/out_stall | elec_angle, position_counts, velocity_q16, primed
//  config  | cfg_we              | cfg_addr, cfg_wdata
//
// One word is taken every cycle unless the input stalls; a word passes the input register
// and then the result register, which lie around the single filter multiply.
// Reset restores the register defaults and clears the tracker state; no clearing pass.
// A stalled result holds in the result register while one more word waits in the input
// register; the input stalls only when both are full.
`default_nettype none

module encoder_angle_velocity_tracker_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [eavt_pkg::CFG_A_W-1:0]          cfg_addr,
	input  logic [eavt_pkg::CFG_W-1:0]            cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [eavt_pkg::COUNT_BITS-1:0]       raw_count,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [eavt_pkg::COUNT_BITS-1:0]       elec_angle,
	output logic signed [eavt_pkg::POS_W-1:0]     position_counts,
	output logic signed [eavt_pkg::VEL_W-1:0]     velocity_q16,
	output logic                                  primed
);

	logic [eavt_pkg::ZERO_W-1:0]  zero_offset_q;
	logic [eavt_pkg::PP_W-1:0]    pole_pairs_q;
	logic [eavt_pkg::ALPHA_W-1:0] filter_alpha_q;

	logic                              valid_s1;
	logic [eavt_pkg::COUNT_BITS-1:0]   raw_s1;

	logic [eavt_pkg::COUNT_BITS-1:0]   last_count_q;
	logic                              started_q;
	logic signed [eavt_pkg::POS_W-1:0] position_q;
	logic signed [eavt_pkg::VEL_W-1:0] velocity_q;

	logic                              out_valid_q;
	logic [eavt_pkg::COUNT_BITS-1:0]   elec_q;
	logic signed [eavt_pkg::POS_W-1:0] pos_out_q;
	logic signed [eavt_pkg::VEL_W-1:0] vel_out_q;
	logic                              primed_q;

	logic out_free;
	logic advance;
	logic accept_in;

	logic [eavt_pkg::COUNT_BITS-1:0]      rel;
	logic [eavt_pkg::ELEC_W-1:0]          elec_full;
	logic signed [eavt_pkg::CDIFF_W-1:0]  cdiff;
	logic signed [eavt_pkg::CDIFF_W-1:0]  cfold;
	logic signed [eavt_pkg::D_W-1:0]      d;
	logic signed [eavt_pkg::POS_W:0]      pos_sum;
	logic signed [eavt_pkg::POS_W-1:0]    pos_next;
	logic [eavt_pkg::ALPHA_W-1:0]         alpha_sat;
	logic signed [eavt_pkg::RAW_W-1:0]    raw_vel;
	logic signed [eavt_pkg::DIFF_W-1:0]   diff;
	logic signed [eavt_pkg::PROD_W-1:0]   prod;
	logic signed [eavt_pkg::PROD_W-1:0]   vsum;
	logic signed [eavt_pkg::VEL_W-1:0]    vel_next;

	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign accept_in = in_valid && !in_stall;

	assign rel       = raw_s1 - zero_offset_q;
	assign elec_full = eavt_pkg::ELEC_W'(rel) * eavt_pkg::ELEC_W'(pole_pairs_q);

	assign cdiff = $signed({2'b00, raw_s1}) - $signed({2'b00, last_count_q});

	always_comb begin
		if (cdiff > eavt_pkg::CNT_HALF) begin
			cfold = cdiff - eavt_pkg::CNT_FULL;
		end else if (cdiff < -eavt_pkg::CNT_HALF) begin
			cfold = cdiff + eavt_pkg::CNT_FULL;
		end else begin
			cfold = cdiff;
		end
	end

	assign d = cfold[eavt_pkg::D_W-1:0];

	assign pos_sum = $signed({position_q[eavt_pkg::POS_W-1], position_q})
		+ $signed({{(eavt_pkg::POS_W + 1 - eavt_pkg::D_W){d[eavt_pkg::D_W-1]}}, d});

	always_comb begin
		if (pos_sum[eavt_pkg::POS_W] != pos_sum[eavt_pkg::POS_W-1]) begin
			pos_next = pos_sum[eavt_pkg::POS_W] ? eavt_pkg::POS_MIN : eavt_pkg::POS_MAX;
		end else begin
			pos_next = pos_sum[eavt_pkg::POS_W-1:0];
		end
	end

	assign alpha_sat = (filter_alpha_q > eavt_pkg::Q_ONE) ? eavt_pkg::Q_ONE : filter_alpha_q;
	assign raw_vel   = {d, {eavt_pkg::FRAC_BITS{1'b0}}};
	assign diff = $signed({{(eavt_pkg::DIFF_W - eavt_pkg::RAW_W){raw_vel[eavt_pkg::RAW_W-1]}},
		raw_vel})
		- $signed({{(eavt_pkg::DIFF_W - eavt_pkg::VEL_W){velocity_q[eavt_pkg::VEL_W-1]}},
		velocity_q});
	assign prod = $signed({1'b0, alpha_sat}) * diff;
	assign vsum = (prod >>> eavt_pkg::FRAC_BITS)
		+ $signed({{(eavt_pkg::PROD_W - eavt_pkg::VEL_W){velocity_q[eavt_pkg::VEL_W-1]}},
		velocity_q});

	always_comb begin
		if (vsum > eavt_pkg::VEL_MAX_X) begin
			vel_next = eavt_pkg::VEL_MAX;
		end else if (vsum < eavt_pkg::VEL_MIN_X) begin
			vel_next = eavt_pkg::VEL_MIN;
		end else begin
			vel_next = vsum[eavt_pkg::VEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_offset_q  <= eavt_pkg::ZERO_OFFSET_RST;
			pole_pairs_q   <= eavt_pkg::POLE_PAIRS_RST;
			filter_alpha_q <= eavt_pkg::FILTER_ALPHA_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				eavt_pkg::REG_ZERO_OFFSET: begin
					zero_offset_q <= cfg_wdata[eavt_pkg::ZERO_W-1:0];
				end
				eavt_pkg::REG_POLE_PAIRS: begin
					pole_pairs_q <= cfg_wdata[eavt_pkg::PP_W-1:0];
				end
				eavt_pkg::REG_FILTER_ALPHA: begin
					filter_alpha_q <= cfg_wdata[eavt_pkg::ALPHA_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			last_count_q <= '0;
			started_q    <= 1'b0;
			position_q   <= '0;
			velocity_q   <= '0;
		end else begin
			valid_s1    <= in_stall ? 1'b1 : in_valid;
			out_valid_q <= advance ? 1'b1 : (out_valid_q && out_stall);
			if (advance) begin
				last_count_q <= raw_s1;
				started_q    <= 1'b1;
				if (started_q) begin
					position_q <= pos_next;
					velocity_q <= vel_next;
				end else begin
					velocity_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			raw_s1 <= raw_count;
		end
		if (advance) begin
			elec_q    <= elec_full[eavt_pkg::COUNT_BITS-1:0];
			pos_out_q <= started_q ? pos_next : position_q;
			vel_out_q <= started_q ? vel_next : '0;
			primed_q  <= started_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign elec_angle      = elec_q;
	assign position_counts = pos_out_q;
	assign velocity_q16    = vel_out_q;
	assign primed          = primed_q;

endmodule

`default_nettype wire

// ===== hdl/eavt_checker.sv =====
// Port-level checker of the encoder angle and velocity tracker and its bind to the top level.
`default_nettype none

`include "encoder_angle_velocity_tracker_unit_assert.svh"

module eavt_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_stall,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic [eavt_pkg::COUNT_BITS-1:0]       elec_angle,
	input logic signed [eavt_pkg::POS_W-1:0]     position_counts,
	input logic signed [eavt_pkg::VEL_W-1:0]     velocity_q16,
	input logic                                  primed
);

	logic seen_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_out_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			seen_out_q <= 1'b1;
		end
	end

	`EAVT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(elec_angle) && $stable(position_counts) && $stable(velocity_q16) && $stable(primed), "stalled result word changed")
	`EAVT_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall, "input stalled while the result side was free")
	`EAVT_ASSERT_NOW(a_first_unprimed, out_valid && !seen_out_q, !primed && velocity_q16 == '0, "first result after reset is not an unprimed word with zero velocity")
	`EAVT_ASSERT_NOW(a_later_primed, out_valid && seen_out_q, primed, "result after the first one is not primed")

endmodule

bind encoder_angle_velocity_tracker_unit eavt_checker u_eavt_checker (.*);

`default_nettype wire
